[sv/hex_escape_decoder_unit_assert.svh]
`ifndef HEX_ESCAPE_DECODER_UNIT_ASSERT_SVH
`define HEX_ESCAPE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked once reset is released
`define HED_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked once reset is released
`define HED_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/hed_pkg.sv]
package hed_pkg;

  // Characters with a meaning to the parser
  localparam logic [7:0] BslChar = 8'h5C;
  localparam logic [7:0] LowerX  = 8'h78;
  localparam logic [7:0] UpperX  = 8'h58;

  // One input byte yields at most this many output bytes
  localparam int GroupMax = 3;
  localparam int GrpCntW  = $clog2(GroupMax + 1);
  localparam int GrpIdxW  = $clog2(GroupMax);

  // Group queue between parser and serialiser
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef logic [GrpCntW-1:0] grp_cnt_t;
  typedef logic [GrpIdxW-1:0] grp_idx_t;

  // Output bytes caused by one accepted input byte
  typedef struct packed {
    logic [GroupMax-1:0][7:0] data;
    grp_cnt_t                 cnt;
    logic                     last;
  } group_t;

  // Parser modes, one-hot
  typedef enum logic [3:0] {
    MODE_PLAIN = 4'b0001,
    MODE_ESC   = 4'b0010,
    MODE_X     = 4'b0100,
    MODE_X1    = 4'b1000
  } mode_e;

  function automatic logic hex_is(input logic [7:0] c);
    hex_is = ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h41) && (c <= 8'h46)) ||
             ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  // Nibble value of a hex digit character; letters sit at low nibble 1..6
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    if (c <= 8'h39) begin
      hex_val = c[3:0];
    end else begin
      hex_val = c[3:0] + 4'd9;
    end
  endfunction

endpackage

[sv/hed_front.sv]
`include "hex_escape_decoder_unit_assert.svh"

module hed_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_i_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  input  logic            q_full_i,
  output logic            push_o,
  output hed_pkg::group_t push_grp_o
);
  import hed_pkg::*;

  mode_e      mode_q, mode_d;
  logic       mk_q, mk_d;
  logic [7:0] held_q, held_d;
  logic       accept;
  logic [7:0] mk_char;
  logic       plain_emit;
  group_t     grp;

  assign in_ready_i_o = !q_full_i;
  assign accept       = in_valid_i && !q_full_i;
  assign mk_char      = mk_q ? UpperX : LowerX;
  // A backslash in plain text opens an escape unless it ends the string
  assign plain_emit   = !((in_byte_i == BslChar) && !in_last_i);

  // Classify the byte against the current mode
  always_comb begin
    grp      = '0;
    grp.last = in_last_i;
    mode_d   = mode_q;
    mk_d     = mk_q;
    held_d   = held_q;
    case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_PLAIN;
        if (in_byte_i == BslChar) begin
          grp.data[0] = BslChar;
          grp.cnt     = grp_cnt_t'(1);
        end else if ((in_byte_i == LowerX) || (in_byte_i == UpperX)) begin
          mk_d = (in_byte_i == UpperX);
          if (in_last_i) begin
            grp.data[0] = in_byte_i;
            grp.cnt     = grp_cnt_t'(1);
          end else begin
            mode_d = MODE_X;
          end
        end else begin
          grp.data[0] = BslChar;
          grp.data[1] = in_byte_i;
          grp.cnt     = grp_cnt_t'(2);
        end
      end
      MODE_X: begin
        if (hex_is(in_byte_i)) begin
          if (in_last_i) begin
            grp.data[0] = mk_char;
            grp.data[1] = in_byte_i;
            grp.cnt     = grp_cnt_t'(2);
            mode_d      = MODE_PLAIN;
          end else begin
            held_d = in_byte_i;
            mode_d = MODE_X1;
          end
        end else begin
          // broken escape: letter, then the byte as plain text
          grp.data[0] = mk_char;
          grp.data[1] = in_byte_i;
          grp.cnt     = plain_emit ? grp_cnt_t'(2) : grp_cnt_t'(1);
          mode_d      = plain_emit ? MODE_PLAIN : MODE_ESC;
        end
      end
      MODE_X1: begin
        if (hex_is(in_byte_i)) begin
          grp.data[0] = {hex_val(held_q), hex_val(in_byte_i)};
          grp.cnt     = grp_cnt_t'(1);
          mode_d      = MODE_PLAIN;
        end else begin
          grp.data[0] = mk_char;
          grp.data[1] = held_q;
          grp.data[2] = in_byte_i;
          grp.cnt     = plain_emit ? grp_cnt_t'(3) : grp_cnt_t'(2);
          mode_d      = plain_emit ? MODE_PLAIN : MODE_ESC;
        end
      end
      default: begin
        grp.data[0] = in_byte_i;
        grp.cnt     = plain_emit ? grp_cnt_t'(1) : grp_cnt_t'(0);
        mode_d      = plain_emit ? MODE_PLAIN : MODE_ESC;
      end
    endcase
    // End of string: back to reset state
    if (in_last_i) begin
      mode_d = MODE_PLAIN;
      mk_d   = 1'b0;
      held_d = '0;
    end
  end

  assign push_o     = accept && (grp.cnt != '0);
  assign push_grp_o = grp;

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      mk_q   <= 1'b0;
      held_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      mk_q   <= mk_d;
      held_q <= held_d;
    end
  end

  `HED_ASSERT_NXT(a_last_resets_mode, accept && in_last_i, mode_q == MODE_PLAIN,
                  "mode not plain after end of string")
  `HED_ASSERT_IMP(a_held_is_hex, mode_q == MODE_X1, hex_is(held_q),
                  "held digit is not a hex digit")
  `HED_ASSERT_NXT(a_bsl_opens_esc,
                  accept && !in_last_i && (mode_q == MODE_PLAIN) && (in_byte_i == BslChar),
                  mode_q == MODE_ESC, "backslash did not open an escape")

endmodule

[sv/hed_queue.sv]
`include "hex_escape_decoder_unit_assert.svh"

module hed_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hed_pkg::group_t push_grp_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output hed_pkg::group_t head_o
);
  import hed_pkg::*;

  localparam logic [QueueCntW-1:0] DepthCnt = QueueCntW'(QueueDepth);
  localparam logic [QueuePtrW-1:0] LastPtr  = QueuePtrW'(QueueDepth - 1);

  group_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]   count_q;

  assign full_o  = (count_q == DepthCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_grp_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `HED_ASSERT_IMP(a_no_overflow, push_i, !full_o, "push into a full queue")
  `HED_ASSERT_IMP(a_no_underflow, pop_i, !empty_o, "pop from an empty queue")
  `HED_ASSERT_IMP(a_count_range, 1'b1, count_q <= DepthCnt, "fill count out of range")

endmodule

[sv/hed_back.sv]
module hed_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  hed_pkg::group_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);
  import hed_pkg::*;

  grp_idx_t   idx_q;
  logic       ovalid_q;
  logic [7:0] obyte_q;
  logic       olast_q;
  logic       take;
  logic       grp_end;

  // Load the output register whenever it is free or being drained
  assign take    = !empty_i && (!ovalid_q || out_ready_i);
  assign grp_end = (grp_cnt_t'(idx_q) == (head_i.cnt - grp_cnt_t'(1)));
  assign pop_o   = take && grp_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (take) begin
        idx_q <= grp_end ? '0 : idx_q + 1'b1;
      end
      if (take) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      obyte_q <= head_i.data[idx_q];
      olast_q <= head_i.last && grp_end;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;

endmodule

[sv/hex_escape_decoder_unit.sv]
// Backslash escape decoder for a byte stream.
// Input stream s_axis: one text byte per transfer in tdata, tlast on the
// final byte of a string. Output stream m_axis: decoded bytes, tlast on the
// last byte produced by the input byte that carried tlast (a string whose
// end produces no byte gives no tlast).
// Escapes: "\\" gives a backslash, "\xHH" or "\XHH" gives byte 0xHH, a broken
// \x escape yields its letter and held digit as text, any other "\c" is kept.
// Throughput: one input byte per cycle; each input byte causes 0 to 3 output
// bytes, drained at one byte per cycle while m_axis_tready stays high. A
// four-entry queue of byte groups between the parser and the output
// serialiser absorbs the extra bytes; s_axis_tready drops only while that
// queue is full. An output byte is written into a queue slot and then loaded
// into the output register, from which m_axis presents it.
// Reset: queue empty, output invalid, parser back in plain text mode.
// A stalled receiver holds the output register; the queue keeps accepting
// input until it fills.
module hex_escape_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_byte
  output logic       m_axis_tlast
);
  import hed_pkg::*;

  logic   push, full, pop, empty;
  group_t push_grp, head_grp;

  // Parser: classifies each byte into a group of output bytes
  hed_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i_o (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .q_full_i     (full),
    .push_o       (push),
    .push_grp_o   (push_grp)
  );

  // Group queue
  hed_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_grp_i (push_grp),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head_grp)
  );

  // Serialiser with output register
  hed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head_grp),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

[tb/testbench.sv]
module testbench;
  import hed_pkg::*;

  // One byte on either stream, with its end-of-string flag
  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_last;
  } text_beat_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tlast;

  // Pending input bytes and decoded bytes still to arrive
  text_beat_t text_q[$];
  text_beat_t decoded_q[$];
  logic [7:0] str_q[$];
  logic [7:0] step_out[$];

  // Predictor state
  mode_e      pmode       = MODE_PLAIN;
  logic       x_upper     = 1'b0;
  logic [7:0] first_digit = 8'h00;

  int queued_count   = 0;
  int string_count   = 0;
  int accepted_count = 0;
  int output_count   = 0;
  int stall_cycles   = 0;
  int mismatch_count = 0;
  bit in_fire        = 1'b0;

  int send_gap      = 0;
  int send_calm     = 0;
  int hold_left     = 0;
  int ready_calm    = 0;
  bit pressure_done = 1'b0;
  bit pressure_on   = 1'b0;

  hex_escape_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic bit is_hex_digit(input logic [7:0] c);
    case (c) inside
      [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61) v = c - 8'h57;
    else v = c - 8'h37;
    return v[3:0];
  endfunction

  function automatic logic [7:0] rand_hex();
    int n;
    n = $urandom_range(0, 21);
    if (n < 10) return 8'h30 + n[7:0];
    if (n < 16) return 8'h61 + n[7:0] - 8'd10;
    return 8'h41 + n[7:0] - 8'd16;
  endfunction

  function automatic logic [7:0] rand_marker();
    return $urandom_range(0, 1) ? UpperX : LowerX;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic emit(input logic [7:0] b);
    step_out.push_back(b);
  endtask

  // Byte seen in plain text mode: a backslash opens an escape unless it ends the string
  task automatic plain_byte(input logic [7:0] c, input logic last);
    if (c == BslChar) begin
      if (last) emit(c);
      else pmode = MODE_ESC;
    end else begin
      emit(c);
    end
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic last);
    logic [7:0] letter;
    letter = x_upper ? UpperX : LowerX;
    step_out.delete();
    case (pmode)
      MODE_PLAIN: plain_byte(c, last);
      MODE_ESC: begin
        pmode = MODE_PLAIN;
        if (c == BslChar) begin
          emit(c);
        end else if (c == LowerX || c == UpperX) begin
          x_upper = (c == UpperX);
          if (last) emit(c);
          else pmode = MODE_X;
        end else begin
          emit(BslChar);
          emit(c);
        end
      end
      MODE_X: begin
        pmode = MODE_PLAIN;
        if (is_hex_digit(c)) begin
          if (last) begin
            emit(letter);
            emit(c);
          end else begin
            first_digit = c;
            pmode = MODE_X1;
          end
        end else begin
          emit(letter);
          plain_byte(c, last);
        end
      end
      default: begin
        pmode = MODE_PLAIN;
        if (is_hex_digit(c)) begin
          emit({nibble_of(first_digit), nibble_of(c)});
        end else begin
          emit(letter);
          emit(first_digit);
          plain_byte(c, last);
        end
      end
    endcase
    foreach (step_out[i])
      decoded_q.push_back('{byte_val: step_out[i],
                            is_last: last && (i == step_out.size() - 1)});
    // End of string puts the parser back to its reset state
    if (last) begin
      pmode = MODE_PLAIN;
      x_upper = 1'b0;
      first_digit = 8'h00;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic put_chars(input string s);
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endtask

  // Close the current string: tlast on its final byte
  task automatic commit_string();
    foreach (str_q[i])
      text_q.push_back('{byte_val: str_q[i], is_last: (i == str_q.size() - 1)});
    queued_count += str_q.size();
    string_count++;
    str_q.delete();
  endtask

  // One well-formed piece of text, or a deliberately broken escape
  task automatic add_token();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        b = 8'($urandom_range(8'h20, 8'h7E));
        str_q.push_back((b == BslChar) ? 8'h61 : b);
      end
      3: put_chars("\\\\");
      4, 5, 6: begin
        str_q.push_back(BslChar);
        str_q.push_back(rand_marker());
        str_q.push_back(rand_hex());
        str_q.push_back(rand_hex());
      end
      7: begin
        str_q.push_back(BslChar);
        str_q.push_back(rand_marker());
        if ($urandom_range(0, 1)) str_q.push_back(rand_hex());
        b = $urandom_range(0, 3) == 0 ? BslChar : 8'($urandom_range(0, 255));
        str_q.push_back(is_hex_digit(b) ? 8'h7A : b);
      end
      8: begin
        str_q.push_back(BslChar);
        str_q.push_back(8'($urandom_range(0, 255)));
      end
      default: str_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  // Noise rich in backslashes, markers and digits
  task automatic add_noise_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) str_q.push_back(BslChar);
    else if (r < 45) str_q.push_back(rand_marker());
    else if (r < 70) str_q.push_back(rand_hex());
    else str_q.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int ntok;
    // Directed strings
    str_q.push_back(8'h00);
    str_q.push_back(8'hFF);
    commit_string();
    put_chars("\\\\");
    commit_string();
    put_chars("\\x41");
    commit_string();
    put_chars("\\XfF");
    commit_string();
    put_chars("\\xg");
    commit_string();
    // escape broken by a backslash that then ends the string
    put_chars("\\X4\\");
    commit_string();
    put_chars("\\q");
    commit_string();
    // escape cut by the end of the string
    put_chars("\\x");
    commit_string();
    put_chars("\\xa");
    commit_string();
    str_q.push_back(BslChar);
    str_q.push_back(LowerX);
    str_q.push_back(8'h80);
    commit_string();
    // Random strings
    while (queued_count < 380) begin
      if ($urandom_range(0, 9) < 7) begin
        ntok = $urandom_range(1, 5);
        repeat (ntok) add_token();
      end else begin
        ntok = $urandom_range(1, 10);
        repeat (ntok) add_noise_byte();
      end
      commit_string();
    end

    // Drain
    wait (text_q.size() == 0 && !s_axis_tvalid);
    wait (decoded_q.size() == 0);
    repeat (10) @(posedge clk_i);
    $display("covered %0d strings: %0d bytes in, %0d bytes out",
             string_count, accepted_count, output_count);
    $display("input held off for %0d cycles by output back-pressure", stall_cycles);
    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3200000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (send_gap > 0 && !pressure_on) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (text_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= text_q[0].byte_val;
        s_axis_tlast  <= text_q[0].is_last;
        void'(text_q.pop_front());
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(10, 40);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output receiver, with one long hold-off to fill the block
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (!pressure_done && accepted_count >= 150) begin
        hold_left = 120;
        pressure_done = 1'b1;
        pressure_on = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        pressure_on = 1'b0;
        m_axis_tready <= 1'b1;
        if (ready_calm > 0) begin
          ready_calm--;
        end else begin
          hold_left = pick_gap();
          if ($urandom_range(0, 19) == 0) ready_calm = $urandom_range(10, 40);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input transfers, check output transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    text_beat_t want;
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && !s_axis_tready) stall_cycles++;
    if (in_fire) begin
      decode_byte(s_axis_tdata, s_axis_tlast);
      accepted_count++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      output_count++;
      if (decoded_q.size() == 0) begin
        $error("unexpected output transfer: out_byte %h out_last %b",
               m_axis_tdata, m_axis_tlast);
        mismatch_count++;
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tdata !== want.byte_val) begin
          $error("out_byte: expected %h, actual %h", want.byte_val, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.is_last) begin
          $error("out_last: expected %b, actual %b", want.is_last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

endmodule
